// ===== rtl/core/es2d_pkg.sv =====
// Constants and helper function for the epoch seconds to civil date pipeline.
package es2d_pkg;

   // pipeline depth, input register stage through output register
   localparam int unsigned STAGES = 7;

   // lowest timestamp that yields a date
   localparam logic [31:0] VALID_FLOOR = 32'd1000000000;

   // seconds per day is 128 * 675; reciprocal of 675 scaled by 2^35
   localparam int unsigned DAY_SHIFT_IN = 7;
   localparam logic [25:0] DAY_RECIP    = 26'd50903317;
   localparam int unsigned DAY_FRAC     = 35;

   // day of era = days + 719468 - 5 * 146097 (era is 5 for every valid timestamp)
   localparam logic [15:0] ERA_OFFSET = 16'd11017;

   // reciprocal of 365 scaled by 2^23, applied to doe / 4 for doe / 1460
   localparam logic [14:0] QUAD_RECIP = 15'd22983;
   localparam int unsigned QUAD_FRAC  = 23;

   // days per century for the century correction
   localparam logic [15:0] CENTURY_DAYS = 16'd36524;

   // reciprocal of 365 scaled by 2^25 for year of era
   localparam logic [16:0] YEAR_RECIP = 17'd91930;
   localparam int unsigned YEAR_FRAC  = 25;

   // reciprocal of 153 scaled by 2^20 for the March-based month
   localparam logic [12:0] MONTH_RECIP = 13'd6854;
   localparam int unsigned MONTH_FRAC  = 20;

   // first year of the era that holds every valid timestamp
   localparam logic [11:0] ERA_BASE_YEAR = 12'd2000;

   // first day of each March-based month within the year, (153 * mp + 2) / 5
   function automatic logic [8:0] month_start(input logic [4:0] mp);
      logic [8:0] start;
      case (mp)
         5'd0:    start = 9'd0;
         5'd1:    start = 9'd31;
         5'd2:    start = 9'd61;
         5'd3:    start = 9'd92;
         5'd4:    start = 9'd122;
         5'd5:    start = 9'd153;
         5'd6:    start = 9'd184;
         5'd7:    start = 9'd214;
         5'd8:    start = 9'd245;
         5'd9:    start = 9'd275;
         5'd10:   start = 9'd306;
         5'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_date.sv =====
// Registered stages carry each accepted request to its response. Throughput: one
// transaction per cycle unless a stall backs up the stages; each stage holds at most
// one reciprocal multiply, and stages advance independently so bubbles close.
// A stalled response holds its stage and backs up the stages behind it only.
// Reset (synchronous, active high) clears all stage valid bits; data needs none.
// Response tuser[0] is the valid flag; dates below one billion seconds read as zero.
module epoch_seconds_to_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] day_of_month, [8:5] month_number,
                                    // [20:9] year_number, [23:21] zero
   output logic [0:0]  rsp_tuser    // [0] valid_res
);
   import es2d_pkg::*;

   // stage valid bits and load enables
   logic [STAGES:1]   vld_ff;
   logic [STAGES+1:1] ld;

   // per-stage payload
   logic        s1_ok_ff,  s2_ok_ff,  s3_ok_ff,  s4_ok_ff,  s5_ok_ff,  s6_ok_ff;
   logic [15:0] s1_days_ff, s1_days_in;
   logic [15:0] s2_doe_ff,  s2_doe_in;
   logic [15:0] s3_doe_ff,  s3_n_ff,  s3_n_in;
   logic [15:0] s4_doe_ff;
   logic [7:0]  s4_yoe_ff,  s4_yoe_in;
   logic [7:0]  s5_yoe_ff;
   logic [8:0]  s5_doy_ff,  s5_doy_in;
   logic [7:0]  s6_yoe_ff;
   logic [8:0]  s6_doy_ff;
   logic [4:0]  s6_mp_ff,   s6_mp_in;
   logic        s7_ok_ff,   s7_ok_in;
   logic [4:0]  s7_day_ff,  s7_day_in;
   logic [3:0]  s7_mon_ff,  s7_mon_in;
   logic [11:0] s7_year_ff, s7_year_in;

   logic        s1_ok_in;
   logic [50:0] day_prod;
   logic [28:0] quad_prod;
   logic [5:0]  quad_q;
   logic        cent_hit;
   logic [32:0] year_prod;
   logic [1:0]  yoe_div100;
   logic [16:0] elapsed_days;
   logic [16:0] doy_wide;
   logic [11:0] mp_arg;
   logic [24:0] mp_prod;
   logic [8:0]  mstart;
   logic [8:0]  day_wide;

   // a stage loads when empty or when the next stage loads
   always_comb begin
      ld[STAGES+1] = rsp_tready;
      for (int k = STAGES; k >= 1; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   assign req_tready = ld[1];
   assign rsp_tvalid = vld_ff[STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[1]) begin
            vld_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (ld[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: whole days via reciprocal of 675 on seconds / 128
   always_comb begin
      day_prod   = {26'd0, req_tdata[31:DAY_SHIFT_IN]} * {25'd0, DAY_RECIP};
      s1_days_in = day_prod[DAY_FRAC+15:DAY_FRAC];
      s1_ok_in   = req_tdata >= VALID_FLOOR;
   end

   // stage 2: day of era
   assign s2_doe_in = s1_days_ff - ERA_OFFSET;

   // stage 3: doe - doe/1460 + doe/36524 (doe/146096 is always zero here)
   always_comb begin
      quad_prod = {15'd0, s2_doe_ff[15:2]} * {14'd0, QUAD_RECIP};
      quad_q    = quad_prod[QUAD_FRAC+5:QUAD_FRAC];
      cent_hit  = s2_doe_ff >= CENTURY_DAYS;
      s3_n_in   = s2_doe_ff - {10'd0, quad_q} + {15'd0, cent_hit};
   end

   // stage 4: year of era
   always_comb begin
      year_prod = {17'd0, s3_n_ff} * {16'd0, YEAR_RECIP};
      s4_yoe_in = year_prod[YEAR_FRAC+7:YEAR_FRAC];
   end

   // stage 5: day of year from March 1
   always_comb begin
      if (s4_yoe_ff >= 8'd200) begin
         yoe_div100 = 2'd2;
      end else if (s4_yoe_ff >= 8'd100) begin
         yoe_div100 = 2'd1;
      end else begin
         yoe_div100 = 2'd0;
      end
      elapsed_days = 17'd365 * {9'd0, s4_yoe_ff} + {11'd0, s4_yoe_ff[7:2]}
                     - {15'd0, yoe_div100};
      doy_wide  = {1'b0, s4_doe_ff} - elapsed_days;
      s5_doy_in = doy_wide[8:0];
   end

   // stage 6: March-based month, (5 * doy + 2) / 153
   always_comb begin
      mp_arg   = 12'd5 * {3'd0, s5_doy_ff} + 12'd2;
      mp_prod  = {13'd0, mp_arg} * {12'd0, MONTH_RECIP};
      s6_mp_in = mp_prod[MONTH_FRAC+4:MONTH_FRAC];
   end

   // stage 7: day, January-based month, year; zero fields for early timestamps
   always_comb begin
      mstart   = month_start(s6_mp_ff);
      day_wide = s6_doy_ff - mstart + 9'd1;
      s7_ok_in = s6_ok_ff;
      if (s6_mp_ff < 5'd10) begin
         s7_mon_in = 4'(s6_mp_ff + 5'd3);
      end else begin
         s7_mon_in = 4'(s6_mp_ff - 5'd9);
      end
      s7_year_in = ERA_BASE_YEAR + {4'd0, s6_yoe_ff}
                   + {11'd0, (s7_mon_in <= 4'd2)};
      s7_day_in  = day_wide[4:0];
      if (!s6_ok_ff) begin
         s7_mon_in  = '0;
         s7_year_in = '0;
         s7_day_in  = '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_ok_ff   <= s1_ok_in;
         s1_days_ff <= s1_days_in;
      end
      if (ld[2]) begin
         s2_ok_ff  <= s1_ok_ff;
         s2_doe_ff <= s2_doe_in;
      end
      if (ld[3]) begin
         s3_ok_ff  <= s2_ok_ff;
         s3_doe_ff <= s2_doe_ff;
         s3_n_ff   <= s3_n_in;
      end
      if (ld[4]) begin
         s4_ok_ff  <= s3_ok_ff;
         s4_doe_ff <= s3_doe_ff;
         s4_yoe_ff <= s4_yoe_in;
      end
      if (ld[5]) begin
         s5_ok_ff  <= s4_ok_ff;
         s5_yoe_ff <= s4_yoe_ff;
         s5_doy_ff <= s5_doy_in;
      end
      if (ld[6]) begin
         s6_ok_ff  <= s5_ok_ff;
         s6_yoe_ff <= s5_yoe_ff;
         s6_doy_ff <= s5_doy_ff;
         s6_mp_ff  <= s6_mp_in;
      end
      if (ld[7]) begin
         s7_ok_ff   <= s7_ok_in;
         s7_day_ff  <= s7_day_in;
         s7_mon_ff  <= s7_mon_in;
         s7_year_ff <= s7_year_in;
      end
   end

   assign rsp_tdata = {3'd0, s7_year_ff, s7_mon_ff, s7_day_ff};
   assign rsp_tuser = s7_ok_ff;

`ifndef SYNTH
   // an accepted transaction always occupies stage 1 next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[1])
      else $error("accepted transaction did not enter the pipeline");

   // a stalled response keeps its contents
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // flagged responses carry a proper month and a year in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> s7_mon_ff != 4'd0 && s7_mon_ff <= 4'd12
         && s7_day_ff != 5'd0 && s7_year_ff >= 12'd2001 && s7_year_ff <= 12'd2106)
      else $error("date out of range");

   // unflagged responses are all zero
   a_early_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("early timestamp produced nonzero fields");
`endif

endmodule

// ===== test/epoch_seconds_to_date_test.sv =====
// Streaming testbench for the epoch seconds to civil date converter.
`timescale 1ns / 100ps

module epoch_seconds_to_date_test;
   import es2d_pkg::*;

   // calendar constants for the date predictor
   localparam logic [31:0] SECS_PER_DAY = 32'd86400;
   localparam logic [31:0] CIVIL_SHIFT  = 32'd719468;
   localparam logic [31:0] ERA_SPAN     = 32'd146097;
   localparam logic [31:0] CENTURY_SPAN = 32'd36524;
   localparam logic [31:0] QUAD_SPAN_M1 = 32'd1460;
   localparam logic [31:0] ERA_SPAN_M1  = 32'd146096;
   localparam logic [31:0] YEAR_SPAN    = 32'd365;
   localparam logic [31:0] MONTH_SPAN   = 32'd153;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned MAX_WHOLE_DAY = 49709;   // last whole day that fits in 32 bits

   typedef struct packed {
      logic        stamp_ok;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } civil_date_type;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] epoch_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [4:0] day, [8:5] month, [20:9] year, [23:21] zero
   logic [0:0]  rsp_tuser;         // [0] valid_res

   logic [31:0]    seconds_queue[$];
   civil_date_type pending_dates[$];
   int             mismatch_count = 0;
   int             accepted_count = 0;
   logic           req_fire       = 1'b0;

   // sender burst state
   int          burst_left = 1;
   int          gap_left   = 0;

   // receiver stall state
   rx_mode_type rx_mode        = RX_OPEN;
   int          mode_left      = 0;
   int          hold_left      = 0;
   logic        long_hold_done = 1'b0;

   epoch_seconds_to_date u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // civil date from seconds since 1970, via era / day of era / year of era
   function automatic civil_date_type civil_date_of(input logic [31:0] secs);
      civil_date_type date;
      logic [31:0] z, era, doe, yoe, doy, mp, d, m, y;
      date = '0;
      if (secs >= VALID_FLOOR) begin
         z   = secs / SECS_PER_DAY + CIVIL_SHIFT;
         era = z / ERA_SPAN;
         doe = z - era * ERA_SPAN;
         yoe = (doe - doe / QUAD_SPAN_M1 + doe / CENTURY_SPAN - doe / ERA_SPAN_M1) / YEAR_SPAN;
         doy = doe - (YEAR_SPAN * yoe + yoe / 32'd4 - yoe / 32'd100);
         mp  = (32'd5 * doy + 32'd2) / MONTH_SPAN;
         d   = doy - (MONTH_SPAN * mp + 32'd2) / 32'd5 + 32'd1;
         m   = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
         y   = yoe + era * 32'd400 + ((m <= 32'd2) ? 32'd1 : 32'd0);
         date.stamp_ok = 1'b1;
         date.day      = d[4:0];
         date.month    = m[3:0];
         date.year     = y[11:0];
      end
      return date;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   // one random timestamp, weighted toward the valid range and day edges
   function automatic logic [31:0] random_seconds();
      logic [31:0] day;
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(VALID_FLOOR - 1, 0);
         2, 3: begin
            day = $urandom_range(MAX_WHOLE_DAY, 11574);
            return day * SECS_PER_DAY + (($urandom_range(0, 1) == 0) ? 32'd0 : 32'd86399);
         end
         default: return $urandom_range(32'hFFFF_FFFF, VALID_FLOOR);
      endcase
   endfunction

   // request driver: bursts of transactions with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left != 0 || seconds_queue.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= seconds_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // response receiver: changing stall modes plus long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!long_hold_done && accepted_count >= 400) begin
         // long hold so the pipeline fills and backs up the request side
         rsp_tready     <= 1'b0;
         hold_left      <= 150;
         long_hold_done <= 1'b1;
      end else if ($urandom_range(0, 499) == 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= $urandom_range(10, 40);
      end else begin
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 2));
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 1) == 0);
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: check responses, then record accepted requests
   always @(posedge clock) begin
      civil_date_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_dates.size() == 0) begin
               report_mismatch("response with nothing pending", 32'd0, 32'(rsp_tdata));
            end else begin
               want = pending_dates.pop_front();
               if (rsp_tuser[0] !== want.stamp_ok)
                  report_mismatch("valid flag", 32'(want.stamp_ok), 32'(rsp_tuser[0]));
               if (rsp_tdata[4:0] !== want.day)
                  report_mismatch("day of month", 32'(want.day), 32'(rsp_tdata[4:0]));
               if (rsp_tdata[8:5] !== want.month)
                  report_mismatch("month", 32'(want.month), 32'(rsp_tdata[8:5]));
               if (rsp_tdata[20:9] !== want.year)
                  report_mismatch("year", 32'(want.year), 32'(rsp_tdata[20:9]));
               if (rsp_tdata[23:21] !== 3'b000)
                  report_mismatch("padding bits", 32'd0, 32'(rsp_tdata[23:21]));
            end
         end
         if (req_tvalid && req_tready) begin
            pending_dates.push_back(civil_date_of(req_tdata));
            accepted_count <= accepted_count + 1;
         end
         req_fire <= req_tvalid && req_tready;
      end
   end

   // stimulus, reset and end of run
   initial begin
      // directed: floor edges, field extremes, leap days and year carries
      seconds_queue = '{32'd0, 32'd1, 32'd999999999, 32'd1000000000, 32'd1000000001,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                        32'd1009843199, 32'd1009843200, 32'd1078012799, 32'd1078012800,
                        32'd1078099199, 32'd1078099200, 32'd4107455999, 32'd4107456000,
                        32'd4107542399, 32'd4107542400, 32'd4233686399, 32'd4233686400,
                        32'd4233772800, 32'hAAAA_AAAA, 32'h5555_5555};
      repeat (RANDOM_ITEMS) seconds_queue.push_back(random_seconds());

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (seconds_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (4 * STAGES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
